// ----- rtl/bpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded priority queue package
// Shared constants, codes and transaction types for the queue block.
// ----------------------------------------------------------------------------
package bpq_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = 5;
    localparam int COUNT_W    = 5;
    localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [1:0] opcode_t;

    localparam opcode_t OP_ENQ   = 2'd0;
    localparam opcode_t OP_DEQ   = 2'd1;
    localparam opcode_t OP_QUERY = 2'd2;

    typedef struct packed {
        opcode_t                       opcode;
        logic signed [WORD_WIDTH-1:0]  value;
        logic signed [WORD_WIDTH-1:0]  priority_req;
    } cmd_t;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0]  head_value;
        logic signed [WORD_WIDTH-1:0]  head_priority;
        logic [COUNT_W-1:0]            count;
        logic                          is_empty;
        logic                          is_full;
        logic                          rejected;
    } result_t;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0]  prio;
        logic signed [WORD_WIDTH-1:0]  value;
    } entry_t;

    typedef struct packed {
        logic              clear;
        logic              valid;
        logic [IDX_W-1:0]  idx;
    } cmp_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/bpq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module bpq_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/bpq_cmp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded priority queue compare unit
// Signed priority comparator that keeps the earliest best entry of a scan.
// ----------------------------------------------------------------------------
module bpq_cmp
    import bpq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmp_ctl_t         ctl,
    input  entry_t           ent,
    output entry_t           best,
    output logic [IDX_W-1:0] best_idx
);

    logic             have_reg;
    logic             have_next;
    entry_t           best_reg;
    entry_t           best_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             take;

    // strictly greater keeps the earliest entry among equal priorities
    assign take = ctl.valid && (!have_reg || ($signed(ent.prio) > $signed(best_reg.prio)));

    always_comb
    begin
        have_next = have_reg;
        best_next = best_reg;
        idx_next  = idx_reg;
        if (ctl.clear)
        begin
            have_next = 1'b0;
        end
        else if (take)
        begin
            have_next = 1'b1;
            best_next = ent;
            idx_next  = ctl.idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        idx_reg  <= idx_next;
    end

    assign best     = best_reg;
    assign best_idx = idx_reg;

endmodule

// ----- rtl/bounded_priority_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded priority queue
// Priority queue with arrival order among equal priorities, scanned and
// compacted through one entry store and one shared comparator.
// ----------------------------------------------------------------------------
// An enqueue or query scans the entries held after the transaction and then
// strobes done; a dequeue scans for the head, compacts the entries above its
// position and scans the shortened queue once more before done. Each
// scan and compaction step takes one read of the single store read port. A new
// command is taken the cycle after done. The receiver cannot stall results.
// Reset empties the queue and sets capacity to 16; no clearing pass is needed.
module bounded_priority_queue_top
    import bpq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    output logic             done,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CAP_W-1:0] capacity_reg;
    logic [CNT_W-1:0] issue_reg;
    logic [CNT_W-1:0] issue_next;
    logic             rd_valid_reg;
    logic             rd_valid_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] rd_idx_next;
    logic             deq_pend_reg;
    logic             deq_pend_next;
    logic             rejected_reg;
    logic             rejected_next;

    logic             accept;
    logic             full;
    logic             scan_done;
    logic             issue_go;
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] cap_eff;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           rd_ent;

    cmp_ctl_t         cmp_ctl;
    entry_t           best;
    logic [IDX_W-1:0] best_idx;

    assign accept    = start && !busy;
    assign cap_ext   = CMP_W'(capacity_reg);
    assign cap_eff   = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
    assign full      = CMP_W'(count_reg) >= cap_eff;
    assign scan_done = (issue_reg == count_reg) && !rd_valid_reg;
    assign issue_go  = ((state_reg == ST_SCAN) || (state_reg == ST_SHIFT))
                       && (issue_reg < count_reg);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = deq_pend_reg ? ST_SHIFT : ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                if (scan_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next    = count_reg;
        issue_next    = issue_reg;
        deq_pend_next = deq_pend_reg;
        rejected_next = rejected_reg;
        rd_valid_next = issue_go;
        rd_idx_next   = issue_reg[IDX_W-1:0];
        ram_we        = 1'b0;
        ram_waddr     = count_reg[IDX_W-1:0];
        ram_wdata     = rd_ent;
        ram_re        = issue_go;
        ram_raddr     = issue_reg[IDX_W-1:0];
        cmp_ctl.clear = 1'b0;
        cmp_ctl.valid = rd_valid_reg && (state_reg == ST_SCAN);
        cmp_ctl.idx   = rd_idx_reg;

        if (issue_go)
        begin
            issue_next = issue_reg + CNT_W'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    issue_next    = '0;
                    rejected_next = 1'b0;
                    deq_pend_next = 1'b0;
                    cmp_ctl.clear = 1'b1;
                    case (cmd.opcode)
                        OP_ENQ:
                        begin
                            if (full)
                            begin
                                rejected_next = 1'b1;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                ram_wdata.prio  = cmd.priority_req;
                                ram_wdata.value = cmd.value;
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                rejected_next = 1'b1;
                            end
                            else
                            begin
                                deq_pend_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_done && deq_pend_reg)
                begin
                    issue_next    = CNT_W'(best_idx) + CNT_W'(1);
                    deq_pend_next = 1'b0;
                end
            end
            ST_SHIFT:
            begin
                // close the gap: entry i+1 moves down to i
                ram_we    = rd_valid_reg;
                ram_waddr = rd_idx_reg - IDX_W'(1);
                if (scan_done)
                begin
                    count_next    = count_reg - CNT_W'(1);
                    issue_next    = '0;
                    cmp_ctl.clear = 1'b1;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            capacity_reg <= CAP_RESET;
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
            deq_pend_reg <= 1'b0;
            rejected_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            rd_valid_reg <= rd_valid_next;
            deq_pend_reg <= deq_pend_next;
            rejected_reg <= rejected_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
    end

    bpq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_ent)
    );

    bpq_cmp u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cmp_ctl),
        .ent      (rd_ent),
        .best     (best),
        .best_idx (best_idx)
    );

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    always_comb
    begin
        result.head_value    = (count_reg == '0) ? '0 : best.value;
        result.head_priority = (count_reg == '0) ? '0 : best.prio;
        result.count         = COUNT_W'(count_reg);
        result.is_empty      = (count_reg == '0);
        result.is_full       = full;
        result.rejected      = rejected_reg;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("entry count beyond store depth");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.opcode == OP_ENQ) && !full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted enqueue did not add an entry");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SHIFT) && ram_we) |-> (CNT_W'(ram_waddr) < count_reg))
        else $error("compaction write outside held entries");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result");

endmodule
